@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the divider RTL.
// Each macro expands to one labeled concurrent assertion on the rising
// clock edge, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDIV_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion lbl failed");

// The consequent must hold in the cycle after the antecedent.
`define SDIV_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion lbl failed");

`endif

@@ rtl/core/sdiv_pkg.sv @@
// ----------------------------------------------------------------------------
// sdiv_pkg
// Types and constants shared by the saturating signed divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdiv_pkg;

   // Number of quotient bits below the overflow bit, one per cell.
   localparam int QuotBits = 31;

   // Largest quotient magnitude; overflow saturates to plus or minus this.
   localparam logic [31:0] QuotMaxMag = 32'h7FFF_FFFF;

   // Work carried from cell to cell.
   typedef struct packed {
      logic [31:0]         rem;      // partial remainder, below the divisor
      logic [QuotBits-1:0] lq;       // dividend bits still to enter, quotient bits shifted in
      logic [31:0]         dvs_mag;  // divisor magnitude, 0 to 2^31
      logic                neg;      // operand signs differ
      logic                ovf;      // quotient does not fit
      logic                dbz;      // divisor is zero
   } sdiv_work_type;

endpackage

`default_nettype wire

@@ rtl/core/sdiv_front.sv @@
// ----------------------------------------------------------------------------
// sdiv_front
// Takes operand magnitudes, then checks for overflow and seeds the remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdiv_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [63:0]           dividend,
   input  logic [31:0]           divisor,
   output logic                  out_valid,
   output sdiv_pkg::sdiv_work_type out_work,
   input  logic                  out_ready
);
   import sdiv_pkg::*;

   logic          a_valid_ff;
   logic [63:0]   a_mag_dvd_ff;
   logic [31:0]   a_mag_dvs_ff;
   logic          a_neg_ff;
   logic          a_dbz_ff;
   logic          b_valid_ff;
   sdiv_work_type b_work_ff;
   sdiv_work_type b_work_in;
   logic          a_advance;
   logic          b_advance;
   logic [32:0]   hi_part;

   assign b_advance = !b_valid_ff || out_ready;
   assign a_advance = !a_valid_ff || b_advance;
   assign in_ready  = a_advance;

   // The overflow test compares the dividend bits above bit 30 with the divisor.
   always_comb begin
      hi_part           = a_mag_dvd_ff[63:31];
      b_work_in.rem     = hi_part[31:0];
      b_work_in.lq      = a_mag_dvd_ff[QuotBits-1:0];
      b_work_in.dvs_mag = a_mag_dvs_ff;
      b_work_in.neg     = a_neg_ff;
      b_work_in.dbz     = a_dbz_ff;
      b_work_in.ovf     = !a_dbz_ff && (hi_part >= {1'b0, a_mag_dvs_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_advance) begin
            a_valid_ff <= in_valid;
         end
         if (b_advance) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_advance) begin
         a_mag_dvd_ff <= dividend[63] ? (~dividend + 64'd1) : dividend;
         a_mag_dvs_ff <= divisor[31] ? (~divisor + 32'd1) : divisor;
         a_neg_ff     <= dividend[63] ^ divisor[31];
         a_dbz_ff     <= (divisor == 32'd0);
      end
      if (b_advance) begin
         b_work_ff <= b_work_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_work  = b_work_ff;

endmodule

`default_nettype wire

@@ rtl/core/sdiv_cell.sv @@
// ----------------------------------------------------------------------------
// sdiv_cell
// One restoring division step: decides one quotient bit per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sdiv_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sdiv_pkg::sdiv_work_type in_work,
   output logic                  out_valid,
   output sdiv_pkg::sdiv_work_type out_work,
   input  logic                  out_ready
);
   import sdiv_pkg::*;

   logic          valid_ff;
   sdiv_work_type work_ff;
   sdiv_work_type work_in;
   logic          advance;
   logic [32:0]   shifted;
   logic [33:0]   diff;
   logic          fits;

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;

   // Bring down the next dividend bit and try to subtract the divisor.
   always_comb begin
      shifted         = {in_work.rem, in_work.lq[QuotBits-1]};
      diff            = {1'b0, shifted} - {2'b00, in_work.dvs_mag};
      fits            = !diff[33];
      work_in         = in_work;
      work_in.rem     = fits ? diff[31:0] : shifted[31:0];
      work_in.lq      = {in_work.lq[QuotBits-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

   `SDIV_ASSERT_NEXT(a_cell_hold, valid_ff && !out_ready, valid_ff && $stable(work_ff))

endmodule

`default_nettype wire

@@ rtl/core/sdiv_back.sv @@
// ----------------------------------------------------------------------------
// sdiv_back
// Applies the sign and the special cases and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sdiv_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sdiv_pkg::sdiv_work_type in_work,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [31:0]           quotient,
   output logic                  overflow,
   output logic                  divide_by_zero
);
   import sdiv_pkg::*;

   logic        valid_ff;
   logic [31:0] quot_ff;
   logic [31:0] quot_in;
   logic        ovf_ff;
   logic        dbz_ff;
   logic        advance;
   logic [31:0] mag;

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;

   always_comb begin
      if (in_work.ovf) begin
         mag = QuotMaxMag;
      end else begin
         mag = {1'b0, in_work.lq};
      end
      if (in_work.dbz) begin
         quot_in = 32'd0;
      end else if (in_work.neg) begin
         quot_in = ~mag + 32'd1;
      end else begin
         quot_in = mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quot_ff <= quot_in;
         ovf_ff  <= in_work.ovf;
         dbz_ff  <= in_work.dbz;
      end
   end

   assign out_valid      = valid_ff;
   assign quotient       = quot_ff;
   assign overflow       = ovf_ff;
   assign divide_by_zero = dbz_ff;

   `SDIV_ASSERT_SAME(a_dbz_result, valid_ff && dbz_ff, quot_ff == 32'd0 && !ovf_ff)
   `SDIV_ASSERT_SAME(a_ovf_saturate, valid_ff && ovf_ff, quot_ff == QuotMaxMag || quot_ff == (~QuotMaxMag + 32'd1))
   `SDIV_ASSERT_SAME(a_no_min_value, valid_ff, quot_ff != 32'h8000_0000)

endmodule

`default_nettype wire

@@ rtl/core/signed_div_64_by_32_saturating.sv @@
// ----------------------------------------------------------------------------
// signed_div_64_by_32_saturating
// Signed 64 by 32 bit divider with a saturating 32-bit quotient.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled, set by the row of 31 division cells,
// each of which decides one quotient bit and passes its work on unless the next stage stalls.
// Reset clears only the valid bits of the stages; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module signed_div_64_by_32_saturating (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [63:0] req_dividend,
   input  logic signed [31:0] req_divisor,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_quotient,
   output logic               rsp_overflow,
   output logic               rsp_divide_by_zero
);
   import sdiv_pkg::*;

   // The front end forms the operand magnitudes in its first stage. In its
   // second it flags overflow, which happens when the dividend bits from
   // bit 31 up are at least the divisor, and splits the dividend into the
   // starting remainder and the low bits that the cells bring down.
   // Each cell then performs one restoring step. When the item is an
   // overflow or a zero divisor the cells run on meaningless data, and the
   // back end replaces their quotient with the saturated value or zero.
   // Every stage stalls only when it holds an item that cannot move on, so
   // bubbles fill up even while a finished result waits at the output.

   sdiv_work_type chain_work  [0:QuotBits];
   logic          chain_valid [0:QuotBits];
   logic          chain_ready [0:QuotBits];
   logic [31:0]   quot_raw;

   sdiv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .dividend  (req_dividend),
      .divisor   (req_divisor),
      .out_valid (chain_valid[0]),
      .out_work  (chain_work[0]),
      .out_ready (chain_ready[0])
   );

   // The row of cells; cell i decides quotient bit QuotBits-1-i.
   for (genvar i = 0; i < QuotBits; i++) begin : g_cell
      sdiv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_work   (chain_work[i]),
         .out_valid (chain_valid[i+1]),
         .out_work  (chain_work[i+1]),
         .out_ready (chain_ready[i+1])
      );
   end

   // The back end applies the sign and holds the result register.
   sdiv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (chain_valid[QuotBits]),
      .in_ready       (chain_ready[QuotBits]),
      .in_work        (chain_work[QuotBits]),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .quotient       (quot_raw),
      .overflow       (rsp_overflow),
      .divide_by_zero (rsp_divide_by_zero)
   );

   assign rsp_quotient = quot_raw;

endmodule

`default_nettype wire
